// File: hdl/rffsa_pkg.sv
// Shared codes, widths, command and status types of the segment allocator.
package rffsa_pkg;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int ID_W      = 16;
  localparam int LEN_W     = 9;
  localparam int ST_W      = 2;
  localparam int ROW_OUT_W = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  // Default sizes
  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_GAPS  = 128;
  localparam int DEF_MAX_IDS   = 65536;
  localparam int RESET_ROWS    = 256;
  localparam int RESET_WIDTH   = 256;

  // Opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

  // Datapath commands issued by the controller
  typedef enum logic [5:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ISWEEP,
    CMD_CSWEEP,
    CMD_RES_NOSPACE,
    CMD_RES_NOTFOUND,
    CMD_RES_ZERO,
    CMD_ROW_LOAD,
    CMD_ROW_NEXT,
    CMD_GAP_RD,
    CMD_GAP_NEXT,
    CMD_PLACE,
    CMD_DN_RD,
    CMD_DN_WR,
    CMD_CNT_DEC,
    CMD_RF_INIT,
    CMD_RF_ACC,
    CMD_META_WR,
    CMD_ER_TAKE,
    CMD_FR_PREV,
    CMD_FR_END,
    CMD_FR_STOP,
    CMD_FR_BOTH,
    CMD_FR_LEFT,
    CMD_FR_RIGHT,
    CMD_UP_INIT,
    CMD_UP_RD,
    CMD_UP_WR,
    CMD_FR_INS,
    CMD_OUT_PUSH
  } cmd_t;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic len_zero;
    logic id_oob;
    logic sweep_last;
    logic fit_row;
    logic row_last;
    logic i_lt_cnt;
    logic gap_fit;
    logic gap_exact;
    logic dn_more;
    logic up_more;
    logic id_hit;
    logic er_empty;
    logic gs_le_s;
    logic left;
    logic right;
    logic full;
    logic out_busy;
  } stat_t;

endpackage

// File: hdl/rffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: hdl/rffsa_dpath.sv
// Datapath: registers, gap, row and id memories, compares and result register.
module rffsa_dpath #(
  parameter int MAX_ROWS  = rffsa_pkg::DEF_MAX_ROWS,
  parameter int MAX_WIDTH = rffsa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_GAPS  = rffsa_pkg::DEF_MAX_GAPS,
  parameter int MAX_IDS   = rffsa_pkg::DEF_MAX_IDS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rffsa_pkg::cmd_t                     cmd,
  output rffsa_pkg::stat_t                    stat,
  input  logic [rffsa_pkg::OP_W-1:0]          in_opcode,
  input  logic [rffsa_pkg::ID_W-1:0]          in_word_id,
  input  logic [rffsa_pkg::LEN_W-1:0]         in_word_len,
  input  logic                                cfg_wr_en,
  input  logic [rffsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rffsa_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [rffsa_pkg::ST_W-1:0]          out_status,
  output logic [rffsa_pkg::ROW_OUT_W-1:0]     out_row_index
);
  import rffsa_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int PW  = $clog2(MAX_WIDTH + 1);
  localparam int SW  = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
  localparam int CW  = $clog2(MAX_GAPS + 1);
  localparam int IW  = $clog2(MAX_IDS);
  localparam int LW  = ((PW > LEN_W) ? PW : LEN_W) + 1;
  localparam int SWD = (MAX_IDS > MAX_ROWS) ? MAX_IDS : MAX_ROWS;
  localparam int SWW = $clog2(SWD);
  localparam int IDW = 1 + RW + 2 * PW;
  localparam int MW  = CW + PW;
  localparam int GW  = 2 * PW;
  localparam int RC_RST = (RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS;
  localparam int RW_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // Control registers
  logic [RCW-1:0] rc_r;
  logic [PW-1:0]  rw_r;
  logic [SWW-1:0] sweep_r;
  logic           out_valid_r;

  // Payload registers
  logic [OP_W-1:0]      op_r;
  logic [ID_W-1:0]      id_r;
  logic [LEN_W-1:0]     len_r;
  logic [RCW-1:0]       r_r;
  logic [CW-1:0]        i_r, k_r, cnt_r;
  logic [PW-1:0]        s_r, e_r, ps_r, pe_r, cs_r, ce_r, mx_r;
  logic                 cur_ok_r;
  logic [ST_W-1:0]      res_st_r;
  logic [ROW_OUT_W-1:0] res_row_r;
  logic [ST_W-1:0]      out_status_r;
  logic [ROW_OUT_W-1:0] out_row_r;

  // Memory ports
  logic              id_we, meta_we, gap_we;
  logic [IW-1:0]     id_waddr, id_raddr;
  logic [IDW-1:0]    id_wdata, id_rd;
  logic [RW-1:0]     meta_waddr;
  logic [MW-1:0]     meta_wdata, meta_rd;
  logic [RW+SW-1:0]  gap_waddr, gap_raddr;
  logic [GW-1:0]     gap_wdata, gap_rd;

  // Unpacked read fields
  logic          id_rd_vld;
  logic [RW-1:0] id_rd_row;
  logic [PW-1:0] id_rd_s, id_rd_e;
  logic [CW-1:0] meta_rd_cnt;
  logic [PW-1:0] meta_rd_max;
  logic [PW-1:0] gs, ge, glen;
  logic [LW-1:0] new_start;

  // Helper values
  logic [31:0]   cfg_v, id32, sweep32, r32, idrow32;
  logic [RCW-1:0] rc_nxt;
  logic [PW-1:0]  rw_nxt;
  logic [RW-1:0]  row_a;
  logic [CW-1:0]  i_m1, k_p1, k_m1;

  assign {id_rd_vld, id_rd_row, id_rd_s, id_rd_e} = id_rd;
  assign {meta_rd_cnt, meta_rd_max} = meta_rd;
  assign {gs, ge} = gap_rd;
  assign glen = ge - gs;
  assign new_start = LW'(gs) + LW'(len_r);

  assign cfg_v   = 32'(cfg_data);
  assign id32    = 32'(id_r);
  assign sweep32 = 32'(sweep_r);
  assign r32     = 32'(r_r);
  assign idrow32 = 32'(id_rd_row);
  assign row_a   = r_r[RW-1:0];
  assign i_m1    = i_r - CW'(1);
  assign k_p1    = k_r + CW'(1);
  assign k_m1    = k_r - CW'(1);
  assign id_raddr = id32[IW-1:0];

  // Clamp configuration values
  always_comb begin
    if (cfg_v == 32'd0) begin
      rc_nxt = RCW'(1);
      rw_nxt = PW'(1);
    end else begin
      rc_nxt = (cfg_v > 32'(MAX_ROWS))  ? RCW'(MAX_ROWS)  : RCW'(cfg_v);
      rw_nxt = (cfg_v > 32'(MAX_WIDTH)) ? PW'(MAX_WIDTH)  : PW'(cfg_v);
    end
  end

  // Memories
  rffsa_ram #(.WIDTH(IDW), .DEPTH(2 ** IW)) u_id_ram (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(id_raddr), .rdata(id_rd)
  );

  rffsa_ram #(.WIDTH(MW), .DEPTH(2 ** RW)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(row_a), .rdata(meta_rd)
  );

  rffsa_ram #(.WIDTH(GW), .DEPTH(2 ** (RW + SW))) u_gap_ram (
    .clk(clk), .we(gap_we), .waddr(gap_waddr), .wdata(gap_wdata),
    .raddr(gap_raddr), .rdata(gap_rd)
  );

  // Memory address and write control
  always_comb begin
    id_we      = 1'b0;
    id_waddr   = id32[IW-1:0];
    id_wdata   = '0;
    meta_we    = 1'b0;
    meta_waddr = row_a;
    meta_wdata = {cnt_r, mx_r};
    gap_we     = 1'b0;
    gap_waddr  = {row_a, i_r[SW-1:0]};
    gap_wdata  = {s_r, e_r};
    gap_raddr  = {row_a, i_r[SW-1:0]};
    case (cmd)
      CMD_ISWEEP: begin
        id_we      = sweep32 < 32'(MAX_IDS);
        id_waddr   = sweep_r[IW-1:0];
        meta_we    = sweep32 < 32'(MAX_ROWS);
        meta_waddr = sweep_r[RW-1:0];
        meta_wdata = '0;
      end
      CMD_CSWEEP: begin
        id_we      = sweep32 < 32'(MAX_IDS);
        id_waddr   = sweep_r[IW-1:0];
        meta_we    = sweep32 < 32'(rc_r);
        meta_waddr = sweep_r[RW-1:0];
        meta_wdata = {CW'(1), rw_r};
        gap_we     = sweep32 < 32'(rc_r);
        gap_waddr  = {sweep_r[RW-1:0], SW'(0)};
        gap_wdata  = {PW'(0), rw_r};
      end
      CMD_PLACE: begin
        id_we     = 1'b1;
        id_wdata  = {1'b1, row_a, gs, PW'(new_start)};
        gap_we    = 1'b1;
        gap_wdata = {PW'(new_start), ge};
      end
      CMD_DN_RD: gap_raddr = {row_a, k_p1[SW-1:0]};
      CMD_UP_RD: gap_raddr = {row_a, k_m1[SW-1:0]};
      CMD_DN_WR, CMD_UP_WR: begin
        gap_we    = 1'b1;
        gap_waddr = {row_a, k_r[SW-1:0]};
        gap_wdata = gap_rd;
      end
      CMD_META_WR: meta_we = 1'b1;
      CMD_ER_TAKE: begin
        id_we    = 1'b1;
        id_wdata = {1'b0, id_rd[IDW-2:0]};
      end
      CMD_FR_BOTH: begin
        gap_we    = 1'b1;
        gap_waddr = {row_a, i_m1[SW-1:0]};
        gap_wdata = {ps_r, ce_r};
      end
      CMD_FR_LEFT: begin
        gap_we    = 1'b1;
        gap_waddr = {row_a, i_m1[SW-1:0]};
        gap_wdata = {ps_r, e_r};
      end
      CMD_FR_RIGHT: begin
        gap_we    = 1'b1;
        gap_wdata = {s_r, ce_r};
      end
      CMD_FR_INS: gap_we = 1'b1;
      default: begin
      end
    endcase
  end

  // Control registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= RCW'(RC_RST);
      rw_r        <= PW'(RW_RST);
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == REG_ROW_COUNT) begin
        rc_r <= rc_nxt;
      end
      if (cfg_wr_en && cfg_index == REG_ROW_WIDTH) begin
        rw_r <= rw_nxt;
      end
      if (cmd == CMD_LOAD) begin
        sweep_r <= '0;
      end else if (cmd == CMD_ISWEEP || cmd == CMD_CSWEEP) begin
        sweep_r <= sweep_r + SWW'(1);
      end
      // Hold the output word until taken
      if (cmd == CMD_OUT_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_r  <= in_opcode;
        id_r  <= in_word_id;
        len_r <= in_word_len;
        r_r   <= '0;
      end
      CMD_CSWEEP, CMD_RES_ZERO: begin
        res_st_r  <= ST_OK;
        res_row_r <= '0;
      end
      CMD_RES_NOSPACE: begin
        res_st_r  <= ST_NOSPACE;
        res_row_r <= '0;
      end
      CMD_RES_NOTFOUND: begin
        res_st_r  <= ST_NOTFOUND;
        res_row_r <= '0;
      end
      CMD_ROW_LOAD: begin
        cnt_r <= meta_rd_cnt;
        i_r   <= '0;
      end
      CMD_ROW_NEXT: r_r <= r_r + RCW'(1);
      CMD_GAP_NEXT: i_r <= i_r + CW'(1);
      CMD_PLACE: begin
        k_r <= i_r;
      end
      CMD_DN_WR: k_r <= k_p1;
      CMD_CNT_DEC: cnt_r <= cnt_r - CW'(1);
      CMD_RF_INIT: begin
        i_r  <= '0;
        mx_r <= '0;
      end
      CMD_RF_ACC: begin
        if (glen > mx_r) begin
          mx_r <= glen;
        end
        i_r <= i_r + CW'(1);
      end
      CMD_META_WR: begin
        res_st_r  <= ST_OK;
        res_row_r <= r32[ROW_OUT_W-1:0];
      end
      CMD_ER_TAKE: begin
        r_r       <= RCW'(id_rd_row);
        s_r       <= id_rd_s;
        e_r       <= id_rd_e;
        res_st_r  <= ST_OK;
        res_row_r <= idrow32[ROW_OUT_W-1:0];
      end
      CMD_FR_PREV: begin
        ps_r <= gs;
        pe_r <= ge;
        i_r  <= i_r + CW'(1);
      end
      CMD_FR_END: cur_ok_r <= 1'b0;
      CMD_FR_STOP: begin
        cs_r     <= gs;
        ce_r     <= ge;
        cur_ok_r <= 1'b1;
      end
      CMD_FR_BOTH: k_r <= i_r;
      CMD_UP_INIT: k_r <= cnt_r;
      CMD_UP_WR: k_r <= k_m1;
      CMD_FR_INS: cnt_r <= cnt_r + CW'(1);
      CMD_OUT_PUSH: begin
        out_status_r <= res_st_r;
        out_row_r    <= res_row_r;
      end
      default: begin
      end
    endcase
  end

  // Flags for the controller
  always_comb begin
    stat.op         = op_r;
    stat.len_zero   = len_r == '0;
    stat.id_oob     = id32 >= 32'(MAX_IDS);
    stat.sweep_last = sweep32 == 32'(SWD - 1);
    stat.fit_row    = LW'(meta_rd_max) >= LW'(len_r);
    stat.row_last   = (r32 + 32'd1) >= 32'(rc_r);
    stat.i_lt_cnt   = i_r < cnt_r;
    stat.gap_fit    = LW'(glen) >= LW'(len_r);
    stat.gap_exact  = new_start == LW'(ge);
    stat.dn_more    = (32'(k_r) + 32'd1) < 32'(cnt_r);
    stat.up_more    = k_r > i_r;
    stat.id_hit     = id_rd_vld && (idrow32 < 32'(MAX_ROWS));
    stat.er_empty   = id_rd_e <= id_rd_s;
    stat.gs_le_s    = gs <= s_r;
    stat.left       = (i_r != '0) && (pe_r == s_r);
    stat.right      = cur_ok_r && (cs_r == e_r);
    stat.full       = 32'(cnt_r) >= 32'(MAX_GAPS);
    stat.out_busy   = out_valid_r && out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_row_index = out_row_r;
endmodule

// File: hdl/rffsa_ctrl.sv
// Controller: sequences row search, gap scan, list shifts and max refresh.
module rffsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rffsa_pkg::stat_t  stat,
  output rffsa_pkg::cmd_t   cmd
);
  import rffsa_pkg::*;

  typedef enum logic [21:0] {
    S_INIT    = 22'b1 << 0,
    S_IDLE    = 22'b1 << 1,
    S_DISP    = 22'b1 << 2,
    S_CSWEEP  = 22'b1 << 3,
    S_WR_MRD  = 22'b1 << 4,
    S_WR_MCHK = 22'b1 << 5,
    S_WR_GRD  = 22'b1 << 6,
    S_WR_GCHK = 22'b1 << 7,
    S_DN_RD   = 22'b1 << 8,
    S_DN_WR   = 22'b1 << 9,
    S_RF_INIT = 22'b1 << 10,
    S_RF_RD   = 22'b1 << 11,
    S_RF_ACC  = 22'b1 << 12,
    S_ER_ICHK = 22'b1 << 13,
    S_ER_MRD  = 22'b1 << 14,
    S_ER_MCHK = 22'b1 << 15,
    S_FR_RD   = 22'b1 << 16,
    S_FR_CHK  = 22'b1 << 17,
    S_FR_DEC  = 22'b1 << 18,
    S_UP_RD   = 22'b1 << 19,
    S_UP_WR   = 22'b1 << 20,
    S_DONE    = 22'b1 << 21
  } state_t;

  state_t state_r, state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  // Pick the next state and the datapath command
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    case (state_r)
      S_INIT: begin
        cmd = CMD_ISWEEP;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_WRITE: begin
            if (stat.len_zero || stat.id_oob) begin
              cmd       = CMD_RES_NOSPACE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_WR_MCHK;
            end
          end
          OP_ERASE: begin
            if (stat.id_oob) begin
              cmd       = CMD_RES_NOTFOUND;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ER_ICHK;
            end
          end
          OP_CLEAR: state_nxt = S_CSWEEP;
          default: begin
            cmd       = CMD_RES_ZERO;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CSWEEP: begin
        cmd = CMD_CSWEEP;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_WR_MRD: state_nxt = S_WR_MCHK;
      S_WR_MCHK: begin
        if (stat.fit_row) begin
          cmd       = CMD_ROW_LOAD;
          state_nxt = S_WR_GRD;
        end else if (stat.row_last) begin
          cmd       = CMD_RES_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_ROW_NEXT;
          state_nxt = S_WR_MRD;
        end
      end
      S_WR_GRD: begin
        if (stat.i_lt_cnt) begin
          cmd       = CMD_GAP_RD;
          state_nxt = S_WR_GCHK;
        end else begin
          cmd       = CMD_RES_NOSPACE;
          state_nxt = S_DONE;
        end
      end
      S_WR_GCHK: begin
        if (stat.gap_fit) begin
          cmd       = CMD_PLACE;
          state_nxt = stat.gap_exact ? S_DN_RD : S_RF_INIT;
        end else begin
          cmd       = CMD_GAP_NEXT;
          state_nxt = S_WR_GRD;
        end
      end
      // Shift gaps down over the removed slot
      S_DN_RD: begin
        if (stat.dn_more) begin
          cmd       = CMD_DN_RD;
          state_nxt = S_DN_WR;
        end else begin
          cmd       = CMD_CNT_DEC;
          state_nxt = S_RF_INIT;
        end
      end
      S_DN_WR: begin
        cmd       = CMD_DN_WR;
        state_nxt = S_DN_RD;
      end
      // Recompute the row's largest gap
      S_RF_INIT: begin
        cmd       = CMD_RF_INIT;
        state_nxt = S_RF_RD;
      end
      S_RF_RD: begin
        if (stat.i_lt_cnt) begin
          cmd       = CMD_GAP_RD;
          state_nxt = S_RF_ACC;
        end else begin
          cmd       = CMD_META_WR;
          state_nxt = S_DONE;
        end
      end
      S_RF_ACC: begin
        cmd       = CMD_RF_ACC;
        state_nxt = S_RF_RD;
      end
      S_ER_ICHK: begin
        if (!stat.id_hit) begin
          cmd       = CMD_RES_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_ER_TAKE;
          state_nxt = stat.er_empty ? S_DONE : S_ER_MRD;
        end
      end
      S_ER_MRD: state_nxt = S_ER_MCHK;
      S_ER_MCHK: begin
        cmd       = CMD_ROW_LOAD;
        state_nxt = S_FR_RD;
      end
      // Find the first gap that starts past the freed range
      S_FR_RD: begin
        if (stat.i_lt_cnt) begin
          cmd       = CMD_GAP_RD;
          state_nxt = S_FR_CHK;
        end else begin
          cmd       = CMD_FR_END;
          state_nxt = S_FR_DEC;
        end
      end
      S_FR_CHK: begin
        if (stat.gs_le_s) begin
          cmd       = CMD_FR_PREV;
          state_nxt = S_FR_RD;
        end else begin
          cmd       = CMD_FR_STOP;
          state_nxt = S_FR_DEC;
        end
      end
      // Merge with neighbors or insert a new gap unless the list is full
      S_FR_DEC: begin
        if (stat.left && stat.right) begin
          cmd       = CMD_FR_BOTH;
          state_nxt = S_DN_RD;
        end else if (stat.left) begin
          cmd       = CMD_FR_LEFT;
          state_nxt = S_RF_INIT;
        end else if (stat.right) begin
          cmd       = CMD_FR_RIGHT;
          state_nxt = S_RF_INIT;
        end else if (stat.full) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_UP_INIT;
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (stat.up_more) begin
          cmd       = CMD_UP_RD;
          state_nxt = S_UP_WR;
        end else begin
          cmd       = CMD_FR_INS;
          state_nxt = S_RF_INIT;
        end
      end
      S_UP_WR: begin
        cmd       = CMD_UP_WR;
        state_nxt = S_UP_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd       = CMD_OUT_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end
endmodule

// File: hdl/row_first_fit_segment_allocator.sv
// Row first-fit segment allocator: one word in, one result word out, one command at a time.
// Write: each row searched and each gap scanned, shifted and refreshed waits on a
// registered memory read. Erase: each gap scanned, shifted and refreshed waits on the
// registered gap read. Clear: one sweep of max(MAX_IDS, MAX_ROWS) entries, one id entry a
// cycle. A new word is taken the cycle after the result is pushed. After reset a like
// sweep clears the id map and row table with input stalled; config writes are taken as ever.
module row_first_fit_segment_allocator #(
  parameter int MAX_ROWS  = rffsa_pkg::DEF_MAX_ROWS,
  parameter int MAX_WIDTH = rffsa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_GAPS  = rffsa_pkg::DEF_MAX_GAPS,
  parameter int MAX_IDS   = rffsa_pkg::DEF_MAX_IDS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rffsa_pkg::OP_W-1:0]          in_opcode,
  input  logic [rffsa_pkg::ID_W-1:0]          in_word_id,
  input  logic [rffsa_pkg::LEN_W-1:0]         in_word_len,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rffsa_pkg::ST_W-1:0]          out_status,
  output logic [rffsa_pkg::ROW_OUT_W-1:0]     out_row_index,
  input  logic                                cfg_wr_en,
  input  logic [rffsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rffsa_pkg::CFG_W-1:0]         cfg_data
);
  import rffsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rffsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  rffsa_dpath #(
    .MAX_ROWS(MAX_ROWS), .MAX_WIDTH(MAX_WIDTH),
    .MAX_GAPS(MAX_GAPS), .MAX_IDS(MAX_IDS)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_opcode(in_opcode), .in_word_id(in_word_id), .in_word_len(in_word_len),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_stall(out_stall), .out_valid(out_valid), .out_status(out_status),
    .out_row_index(out_row_index)
  );
endmodule

// File: hdl/rffsa_chk.sv
// Port-level checker for the segment allocator and its bind.
module rffsa_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rffsa_pkg::ST_W-1:0]      out_status,
  input logic [rffsa_pkg::ROW_OUT_W-1:0] out_row_index
);
  import rffsa_pkg::*;

  // Input is held off during the clearing pass after reset
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // One command at a time: accepting a word stalls the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // Failures report row zero
  a_fail_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOSPACE || out_status == ST_NOTFOUND)
    |-> out_row_index == '0)
    else $error("failed result with nonzero row");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_row_index))
    else $error("stalled result changed");
endmodule

bind row_first_fit_segment_allocator rffsa_chk u_rffsa_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_row_index(out_row_index)
);
